// ===== sv/gta_pkg.sv =====
// Package for the gateway table with aging: table size, operation codes,
// register map and the command and accumulator types shared by the cells.
// No dependencies.
`default_nettype none

package gta_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PADDR_W       = 4;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  localparam logic [1:0] REG_ROUTE_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_METRIC_CEILING = 2'd1;
  localparam logic [1:0] REG_NULL_ADDRESS   = 2'd2;

  localparam logic [31:0] ROUTE_TIMEOUT_RESET  = 32'd3000;
  localparam logic [31:0] METRIC_CEILING_RESET = 32'hFFFF_FFFF;
  localparam logic [31:0] NULL_ADDRESS_RESET   = 32'd0;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] address;
    logic [31:0] seq;
    logic [7:0]  hops;
    logic [31:0] metric;
    logic [31:0] now;
    logic [31:0] expiry;
    logic [31:0] ceiling;
    logic [31:0] counter;
  } cmd_t;

  typedef struct packed {
    logic             found;
    logic             accepted;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
    logic             have_best;
    logic [31:0]      low_metric;
    logic [31:0]      best_age;
    logic [31:0]      best_addr;
  } acc_t;

  localparam acc_t ACC_INIT = '0;

endpackage

`default_nettype wire

// ===== sv/gta_cell.sv =====
// One table cell: holds one gateway entry and processes the travelling
// command token, handing its accumulated search result to the next cell.
// Depends on gta_pkg.
`default_nettype none

module gta_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  gta_pkg::cmd_t             cmd,
  input  logic [gta_pkg::IDX_W-1:0] cell_index,
  input  logic                      token_in,
  input  gta_pkg::acc_t             acc_in,
  input  logic                      ins_en,
  output logic                      token_out,
  output gta_pkg::acc_t             acc_out
);
  import gta_pkg::*;

  logic        valid;
  logic [31:0] address;
  logic [31:0] seq;
  logic [31:0] metric;
  logic [7:0]  hops;
  logic [31:0] expiry;
  logic [31:0] stamp;

  logic        match;
  logic        refresh_ok;
  logic        do_refresh;
  logic [31:0] expiry_diff;
  logic        expired;
  logic [31:0] age;
  logic        qualify;
  logic        better;
  acc_t        acc_next;

  always_comb begin
    match       = valid && (address == cmd.address);
    refresh_ok  = !(seq > cmd.seq) && !((seq == cmd.seq) && (metric < cmd.metric));
    do_refresh  = token_in && match && (cmd.mode == MODE_UPDATE) && refresh_ok;
    expiry_diff = expiry - cmd.now;
    expired     = valid && expiry_diff[31];
    age         = cmd.counter - stamp;
    qualify     = valid && !expired && (metric < cmd.ceiling);
    better      = !acc_in.have_best || (metric < acc_in.low_metric) ||
                  ((metric == acc_in.low_metric) && (age < acc_in.best_age));
  end

  always_comb begin
    acc_next = acc_in;
    acc_next.found    = acc_in.found | match;
    acc_next.accepted = acc_in.accepted | (match && (cmd.mode == MODE_UPDATE) && refresh_ok);
    if (!acc_in.have_free && !valid) begin
      acc_next.have_free = 1'b1;
      acc_next.free_idx  = cell_index;
    end
    if ((cmd.mode == MODE_TICK) && qualify && better) begin
      acc_next.have_best  = 1'b1;
      acc_next.low_metric = metric;
      acc_next.best_age   = age;
      acc_next.best_addr  = address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      token_out <= 1'b0;
    end else begin
      token_out <= token_in;
      if (ins_en) begin
        valid <= 1'b1;
      end else if (token_in && match && (cmd.mode == MODE_DELETE)) begin
        valid <= 1'b0;
      end else if (token_in && expired && (cmd.mode == MODE_TICK)) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (token_in) begin
      acc_out <= acc_next;
    end
    if (ins_en || do_refresh) begin
      seq    <= cmd.seq;
      metric <= cmd.metric;
      hops   <= cmd.hops;
      expiry <= cmd.expiry;
    end
    if (ins_en) begin
      address <= cmd.address;
      stamp   <= cmd.counter;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gateway_table_with_aging.sv =====
// Top level of the gateway table with aging: register port, command latch,
// the chain of table cells and the result stage.
// Depends on gta_pkg and gta_cell.
//
//   Port group     Handshake              Contents
//   command        start / busy           mode, gw_address, dest_seq, hop_count,
//                                         route_cost, now
//   result         done (one cycle)       accepted, is_gateway, default_gateway,
//                                         table_full
//   registers      psel/penable/pready    route_timeout, metric_ceiling,
//                                         null_address
//
// A command walks the cell chain one cell per cycle, passing from the go register
// through each cell's token register to done, and a new command can be taken
// in the cycle the result is shown. Busy is high from the transfer until then.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// Reset empties the table at once; there is no clearing pass.
`default_nettype none

module gateway_table_with_aging (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  mode,
  input  logic [31:0]                 gw_address,
  input  logic [31:0]                 dest_seq,
  input  logic [7:0]                  hop_count,
  input  logic [31:0]                 route_cost,
  input  logic [31:0]                 now,
  output logic                        done,
  output logic                        accepted,
  output logic                        is_gateway,
  output logic [31:0]                 default_gateway,
  output logic                        table_full,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gta_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gta_pkg::*;

  logic [31:0] route_timeout;
  logic [31:0] metric_ceiling;
  logic [31:0] null_address;
  logic [31:0] insert_counter;
  logic [31:0] current_default;
  logic [31:0] current_default_next;
  logic        go;
  cmd_t        cmd;

  logic                     tok [TABLE_ENTRIES];
  acc_t                     acc [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ins_en;

  logic       take;
  logic       cfg_write;
  logic [1:0] reg_index;
  logic       finish;
  acc_t       last;
  logic       insert_do;

  assign take      = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];
  assign finish    = tok[TABLE_ENTRIES-1];
  assign last      = acc[TABLE_ENTRIES-1];
  assign insert_do = finish && (cmd.mode == MODE_UPDATE) && !last.found && last.have_free;

  always_comb begin
    unique case (reg_index)
      REG_ROUTE_TIMEOUT:  prdata = route_timeout;
      REG_METRIC_CEILING: prdata = metric_ceiling;
      REG_NULL_ADDRESS:   prdata = null_address;
      default:            prdata = 32'd0;
    endcase
  end

  always_comb begin
    current_default_next = current_default;
    if (finish && (cmd.mode == MODE_TICK)) begin
      current_default_next = last.have_best ? last.best_addr : null_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_timeout   <= ROUTE_TIMEOUT_RESET;
      metric_ceiling  <= METRIC_CEILING_RESET;
      null_address    <= NULL_ADDRESS_RESET;
      insert_counter  <= 32'd0;
      current_default <= NULL_ADDRESS_RESET;
      busy            <= 1'b0;
      go              <= 1'b0;
      done            <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_index)
          REG_ROUTE_TIMEOUT:  route_timeout  <= pwdata;
          REG_METRIC_CEILING: metric_ceiling <= pwdata;
          REG_NULL_ADDRESS:   null_address   <= pwdata;
          default:            ;
        endcase
      end
      go              <= take;
      done            <= finish;
      current_default <= current_default_next;
      if (insert_do) begin
        insert_counter <= insert_counter + 32'd1;
      end
      if (take) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd.mode    <= mode_t'(mode);
      cmd.address <= gw_address;
      cmd.seq     <= dest_seq;
      cmd.hops    <= hop_count;
      cmd.metric  <= route_cost;
      cmd.now     <= now;
      cmd.expiry  <= now + route_timeout;
      cmd.ceiling <= metric_ceiling;
      cmd.counter <= insert_counter;
    end
    if (finish) begin
      accepted        <= (cmd.mode == MODE_UPDATE) && (last.accepted || insert_do);
      is_gateway      <= (cmd.mode == MODE_LOOKUP) && last.found;
      table_full      <= (cmd.mode == MODE_UPDATE) && !last.found && !last.have_free;
      default_gateway <= current_default_next;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic tok_in;
    acc_t acc_in;

    if (i == 0) begin : g_head
      assign tok_in = go;
      assign acc_in = ACC_INIT;
    end else begin : g_link
      assign tok_in = tok[i-1];
      assign acc_in = acc[i-1];
    end

    assign ins_en[i] = insert_do && (last.free_idx == IDX_W'(i));

    gta_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cell_index (IDX_W'(i)),
      .token_in   (tok_in),
      .acc_in     (acc_in),
      .ins_en     (ins_en[i]),
      .token_out  (tok[i]),
      .acc_out    (acc[i])
    );
  end

endmodule

`default_nettype wire

// ===== sv/gta_checker.sv =====
// Port-level checker for the gateway table with aging, bound to the top level.
// It sees the command and result handshake ports and the accepted and table_full results.
`default_nettype none

module gta_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic accepted,
  input logic table_full
);

  a_take_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Busy did not rise after a command transfer.");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result shown while the block is still busy.");

  a_busy_falls_with_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("Busy fell without a result.");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Two results in consecutive cycles.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(accepted && table_full))
    else $error("An update was both accepted and refused.");

endmodule

bind gateway_table_with_aging gta_checker u_gta_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .accepted   (accepted),
  .table_full (table_full)
);

`default_nettype wire
